@@ rtl/srl_pkg.sv @@
`default_nettype none
package srl_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int TABLE_COUNT = 4;
   localparam int SYMBOL_BITS = 16;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam int TID_BITS    = $clog2(TABLE_COUNT);
   localparam int SLOT_BITS   = TID_BITS + IDX_BITS;
   localparam int SLOTS       = TABLE_COUNT * TABLE_DEPTH;

   // command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [63:0]            offset;
      logic [63:0]            size;
      logic [SYMBOL_BITS-1:0] symbol;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_RD,
      ST_LD_CMP,
      ST_IN_RD,
      ST_IN_CMP,
      ST_LK_RD,
      ST_LK_CMP,
      ST_EQ_CMP,
      ST_PV_CMP
   } state_type;

endpackage
`default_nettype wire

@@ rtl/srl_ram.sv @@
`default_nettype none
module srl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ rtl/symbol_range_lookup.sv @@
`default_nettype none
// Sorted address-range tables, one per table id, with load and lookup items.
// An item is taken when start is high and busy is low; busy stays high until
// the item's single result has been issued. The result is shown on the rsp_
// ports for one cycle with rsp_valid high and cannot be held off.
// A load item inserts its entry into the table's pending memory in offset
// order; each pending entry with a larger offset moves up one slot (one read
// and one write each).
// A load flagged last then copies the pending entries into the installed
// memory, dropping neighbors with equal offset and size. A full table drops
// the entry with status 1.
// A lookup is a binary search over the installed memory, a read, then a
// compare per step, up to 9 steps for a full table, followed by the exact
// and preceding-entry checks.
// The result is shown in the cycle in which busy falls; a dropped load not
// flagged last never raises busy. The entry memories have a registered read.
// Reset clears the counts and present marks at once; the memories need no
// clearing, since only entries below the counts are read. The first item
// may follow reset in the next cycle.
module symbol_range_lookup (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_command,
   input  wire logic [1:0]                    req_table_id,
   input  wire logic [63:0]                   req_address,
   input  wire logic [63:0]                   req_entry_size,
   input  wire logic [15:0]                   req_symbol_id,
   input  wire logic                          req_last_entry,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic [15:0]                        rsp_match_symbol,
   output logic [63:0]                        rsp_match_offset,
   output logic [63:0]                        rsp_match_size,
   output logic                               rsp_table_present,
   output logic                               rsp_status
);

   localparam int CB = srl_pkg::CNT_BITS;
   localparam int IB = srl_pkg::IDX_BITS;
   localparam int TB = srl_pkg::TID_BITS;
   localparam int SB = srl_pkg::SLOT_BITS;

   srl_pkg::state_type state_ff, state_in;

   logic [TB-1:0]          tid_ff, tid_in;
   logic [63:0]            addr_ff, addr_in;
   srl_pkg::entry_type     item_ff, item_in;
   logic                   last_ff, last_in;
   logic                   drop_ff, drop_in;
   logic [CB-1:0]          pos_ff, pos_in;
   logic [CB-1:0]          lo_ff, lo_in;
   logic [CB-1:0]          hi_ff, hi_in;
   logic [CB-1:0]          mid_ff, mid_in;
   logic [CB-1:0]          rd_idx_ff, rd_idx_in;
   logic [CB-1:0]          wr_idx_ff, wr_idx_in;
   logic [63:0]            prev_off_ff, prev_off_in;
   logic [63:0]            prev_size_ff, prev_size_in;

   logic [CB-1:0]          pend_cnt_ff [srl_pkg::TABLE_COUNT];
   logic [CB-1:0]          pend_cnt_in [srl_pkg::TABLE_COUNT];
   logic [CB-1:0]          ent_cnt_ff  [srl_pkg::TABLE_COUNT];
   logic [CB-1:0]          ent_cnt_in  [srl_pkg::TABLE_COUNT];
   logic [srl_pkg::TABLE_COUNT-1:0] present_ff, present_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   srl_pkg::entry_type     rsp_entry_ff, rsp_entry_in;
   logic                   rsp_present_ff, rsp_present_in;
   logic                   rsp_status_ff, rsp_status_in;

   // memory ports
   logic                   pend_we;
   logic [SB-1:0]          pend_waddr, pend_raddr;
   srl_pkg::entry_type     pend_wdata, pend_rdata;
   logic                   inst_we;
   logic [SB-1:0]          inst_waddr, inst_raddr;
   srl_pkg::entry_type     inst_wdata, inst_rdata;
   logic [CB-1:0]          mid_calc;
   logic [63:0]            end_addr;

   srl_ram #(.WIDTH(srl_pkg::ENTRY_BITS), .DEPTH(srl_pkg::SLOTS)) u_pend_ram (
      .clock (clock),
      .we    (pend_we),
      .waddr (pend_waddr),
      .wdata (pend_wdata),
      .raddr (pend_raddr),
      .rdata (pend_rdata)
   );

   srl_ram #(.WIDTH(srl_pkg::ENTRY_BITS), .DEPTH(srl_pkg::SLOTS)) u_inst_ram (
      .clock (clock),
      .we    (inst_we),
      .waddr (inst_waddr),
      .wdata (inst_wdata),
      .raddr (inst_raddr),
      .rdata (inst_rdata)
   );

   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign end_addr = inst_rdata.offset + inst_rdata.size;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srl_pkg::ST_IDLE;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < srl_pkg::TABLE_COUNT; t++) begin
            pend_cnt_ff[t] <= '0;
            ent_cnt_ff[t]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_cnt_ff  <= pend_cnt_in;
         ent_cnt_ff   <= ent_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tid_ff         <= tid_in;
      addr_ff        <= addr_in;
      item_ff        <= item_in;
      last_ff        <= last_in;
      drop_ff        <= drop_in;
      pos_ff         <= pos_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mid_ff         <= mid_in;
      rd_idx_ff      <= rd_idx_in;
      wr_idx_ff      <= wr_idx_in;
      prev_off_ff    <= prev_off_in;
      prev_size_ff   <= prev_size_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_entry_ff   <= rsp_entry_in;
      rsp_present_ff <= rsp_present_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // sequencer: insert, install and search
   always_comb begin
      state_in       = state_ff;
      tid_in         = tid_ff;
      addr_in        = addr_ff;
      item_in        = item_ff;
      last_in        = last_ff;
      drop_in        = drop_ff;
      pos_in         = pos_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      rd_idx_in      = rd_idx_ff;
      wr_idx_in      = wr_idx_ff;
      prev_off_in    = prev_off_ff;
      prev_size_in   = prev_size_ff;
      pend_cnt_in    = pend_cnt_ff;
      ent_cnt_in     = ent_cnt_ff;
      present_in     = present_ff;
      rsp_valid_in   = 1'b0;
      rsp_found_in   = rsp_found_ff;
      rsp_entry_in   = rsp_entry_ff;
      rsp_present_in = rsp_present_ff;
      rsp_status_in  = rsp_status_ff;
      pend_we        = 1'b0;
      pend_waddr     = {tid_ff, pos_ff[IB-1:0]};
      pend_wdata     = item_ff;
      pend_raddr     = {tid_ff, rd_idx_ff[IB-1:0]};
      inst_we        = 1'b0;
      inst_waddr     = {tid_ff, wr_idx_ff[IB-1:0]};
      inst_wdata     = pend_rdata;
      inst_raddr     = {tid_ff, mid_ff[IB-1:0]};

      case (state_ff)
         srl_pkg::ST_IDLE: begin
            if (start) begin
               tid_in         = req_table_id;
               addr_in        = req_address;
               item_in.offset = req_address;
               item_in.size   = req_entry_size;
               item_in.symbol = req_symbol_id[srl_pkg::SYMBOL_BITS-1:0];
               last_in        = req_last_entry;
               drop_in        = 1'b0;
               rsp_found_in   = 1'b0;
               rsp_entry_in   = '0;
               rsp_status_in  = srl_pkg::STATUS_OK;
               if (req_command == srl_pkg::CMD_LOAD) begin
                  if (pend_cnt_ff[req_table_id] >= CB'(srl_pkg::TABLE_DEPTH)) begin
                     drop_in       = 1'b1;
                     rsp_status_in = srl_pkg::STATUS_FULL;
                     if (req_last_entry) begin
                        rd_idx_in = '0;
                        wr_idx_in = '0;
                        state_in  = srl_pkg::ST_IN_RD;
                     end else begin
                        rsp_present_in = present_ff[req_table_id];
                        rsp_valid_in   = 1'b1;
                     end
                  end else begin
                     pos_in   = pend_cnt_ff[req_table_id];
                     state_in = srl_pkg::ST_LD_RD;
                  end
               end else begin
                  present_in[req_table_id] = 1'b1;
                  lo_in    = '0;
                  hi_in    = ent_cnt_ff[req_table_id];
                  state_in = srl_pkg::ST_LK_RD;
               end
            end
         end

         // walk down from the end of the pending entries
         srl_pkg::ST_LD_RD: begin
            if (pos_ff == '0) begin
               pend_we              = 1'b1;
               pend_cnt_in[tid_ff]  = pend_cnt_ff[tid_ff] + CB'(1);
               if (last_ff) begin
                  rd_idx_in = '0;
                  wr_idx_in = '0;
                  state_in  = srl_pkg::ST_IN_RD;
               end else begin
                  rsp_present_in = present_ff[tid_ff];
                  rsp_valid_in   = 1'b1;
                  state_in       = srl_pkg::ST_IDLE;
               end
            end else begin
               pend_raddr = {tid_ff, IB'(pos_ff - CB'(1))};
               state_in   = srl_pkg::ST_LD_CMP;
            end
         end

         // move a larger entry up one slot or place the new one
         srl_pkg::ST_LD_CMP: begin
            pend_we = 1'b1;
            if (pend_rdata.offset > item_ff.offset) begin
               pend_wdata = pend_rdata;
               pos_in     = pos_ff - CB'(1);
               state_in   = srl_pkg::ST_LD_RD;
            end else begin
               pend_cnt_in[tid_ff] = pend_cnt_ff[tid_ff] + CB'(1);
               if (last_ff) begin
                  rd_idx_in = '0;
                  wr_idx_in = '0;
                  state_in  = srl_pkg::ST_IN_RD;
               end else begin
                  rsp_present_in = present_ff[tid_ff];
                  rsp_valid_in   = 1'b1;
                  state_in       = srl_pkg::ST_IDLE;
               end
            end
         end

         // install: read the next pending entry
         srl_pkg::ST_IN_RD: begin
            if (rd_idx_ff < pend_cnt_ff[tid_ff]) begin
               pend_raddr = {tid_ff, rd_idx_ff[IB-1:0]};
               state_in   = srl_pkg::ST_IN_CMP;
            end else begin
               ent_cnt_in[tid_ff]  = wr_idx_ff;
               pend_cnt_in[tid_ff] = '0;
               present_in[tid_ff]  = 1'b1;
               rsp_present_in      = 1'b1;
               rsp_valid_in        = 1'b1;
               state_in            = srl_pkg::ST_IDLE;
            end
         end

         // install: copy unless it repeats the entry just written
         srl_pkg::ST_IN_CMP: begin
            if (!(wr_idx_ff != '0 && prev_off_ff == pend_rdata.offset &&
                  prev_size_ff == pend_rdata.size)) begin
               inst_we      = 1'b1;
               prev_off_in  = pend_rdata.offset;
               prev_size_in = pend_rdata.size;
               wr_idx_in    = wr_idx_ff + CB'(1);
            end
            rd_idx_in = rd_idx_ff + CB'(1);
            state_in  = srl_pkg::ST_IN_RD;
         end

         // search: probe the middle or go to the final checks
         srl_pkg::ST_LK_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in     = mid_calc;
               inst_raddr = {tid_ff, mid_calc[IB-1:0]};
               state_in   = srl_pkg::ST_LK_CMP;
            end else if (lo_ff < ent_cnt_ff[tid_ff]) begin
               inst_raddr = {tid_ff, lo_ff[IB-1:0]};
               state_in   = srl_pkg::ST_EQ_CMP;
            end else if (lo_ff == '0) begin
               rsp_present_in = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = srl_pkg::ST_IDLE;
            end else begin
               inst_raddr = {tid_ff, IB'(lo_ff - CB'(1))};
               state_in   = srl_pkg::ST_PV_CMP;
            end
         end

         srl_pkg::ST_LK_CMP: begin
            if (inst_rdata.offset < addr_ff) begin
               lo_in = mid_ff + CB'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = srl_pkg::ST_LK_RD;
         end

         // exact offset match
         srl_pkg::ST_EQ_CMP: begin
            if (inst_rdata.offset == addr_ff) begin
               rsp_found_in   = 1'b1;
               rsp_entry_in   = inst_rdata;
               rsp_present_in = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = srl_pkg::ST_IDLE;
            end else if (lo_ff == '0) begin
               rsp_present_in = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = srl_pkg::ST_IDLE;
            end else begin
               inst_raddr = {tid_ff, IB'(lo_ff - CB'(1))};
               state_in   = srl_pkg::ST_PV_CMP;
            end
         end

         // nearest entry below: inside it or open-ended
         srl_pkg::ST_PV_CMP: begin
            if (inst_rdata.offset <= addr_ff &&
                (end_addr > addr_ff || inst_rdata.size == 64'd0)) begin
               rsp_found_in = 1'b1;
               rsp_entry_in = inst_rdata;
            end
            rsp_present_in = 1'b1;
            rsp_valid_in   = 1'b1;
            state_in       = srl_pkg::ST_IDLE;
         end

         default: begin
            state_in = srl_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != srl_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_match_symbol  = 16'(rsp_entry_ff.symbol);
   assign rsp_match_offset  = rsp_entry_ff.offset;
   assign rsp_match_size    = rsp_entry_ff.size;
   assign rsp_table_present = rsp_present_ff;
   assign rsp_status        = rsp_status_ff;

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 4000000;
   localparam int TC = srl_pkg::TABLE_COUNT;
   localparam int TD = srl_pkg::TABLE_DEPTH;
   localparam int SYB = srl_pkg::SYMBOL_BITS;

   typedef struct packed {
      logic        found;
      logic [15:0] symbol;
      logic [63:0] offset;
      logic [63:0] size;
      logic        present;
      logic        status;
   } lookup_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_command;
   logic [1:0]  req_table_id;
   logic [63:0] req_address;
   logic [63:0] req_entry_size;
   logic [15:0] req_symbol_id;
   logic        req_last_entry;
   logic        rsp_valid;
   logic        rsp_found;
   logic [15:0] rsp_match_symbol;
   logic [63:0] rsp_match_offset;
   logic [63:0] rsp_match_size;
   logic        rsp_table_present;
   logic        rsp_status;

   symbol_range_lookup dut (.*);

   // shadow copy of the tables
   logic [63:0]    pend_off [TC][TD];
   logic [63:0]    pend_len [TC][TD];
   logic [SYB-1:0] pend_sym [TC][TD];
   logic [63:0]    inst_off [TC][TD];
   logic [63:0]    inst_len [TC][TD];
   logic [SYB-1:0] inst_sym [TC][TD];
   int             pend_cnt [TC];
   int             inst_cnt [TC];
   logic           present  [TC];

   lookup_result_type expected_results[$];
   int  mismatches;
   int  cycles;
   int  burst_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      lookup_result_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_found, rsp_match_symbol, rsp_match_offset, rsp_match_size,
                 rsp_table_present, rsp_status};
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp f=%b s=%h o=%h z=%h p=%b st=%b ",
                            "got f=%b s=%h o=%h z=%h p=%b st=%b"},
                           want.found, want.symbol, want.offset, want.size, want.present,
                           want.status, got.found, got.symbol, got.offset, got.size,
                           got.present, got.status);
            end
         end
      end
   end

   // load one entry into the shadow pending buffer, install on last
   function automatic lookup_result_type model_load(int t, logic [63:0] off,
                                                    logic [63:0] len,
                                                    logic [15:0] sym, logic last);
      lookup_result_type r;
      int pos, k;
      r = '0;
      if (pend_cnt[t] >= TD) begin
         r.status = srl_pkg::STATUS_FULL;
      end else begin
         pos = pend_cnt[t];
         while (pos > 0 && pend_off[t][pos-1] > off) begin
            pend_off[t][pos] = pend_off[t][pos-1];
            pend_len[t][pos] = pend_len[t][pos-1];
            pend_sym[t][pos] = pend_sym[t][pos-1];
            pos--;
         end
         pend_off[t][pos] = off;
         pend_len[t][pos] = len;
         pend_sym[t][pos] = sym[SYB-1:0];
         pend_cnt[t]++;
      end
      if (last) begin
         k = 0;
         for (int i = 0; i < pend_cnt[t]; i++) begin
            if (k > 0 && inst_off[t][k-1] == pend_off[t][i] &&
                inst_len[t][k-1] == pend_len[t][i])
               continue;
            inst_off[t][k] = pend_off[t][i];
            inst_len[t][k] = pend_len[t][i];
            inst_sym[t][k] = pend_sym[t][i];
            k++;
         end
         inst_cnt[t] = k;
         pend_cnt[t] = 0;
         present[t] = 1'b1;
      end
      r.present = present[t];
      return r;
   endfunction

   // search the shadow installed table
   function automatic lookup_result_type model_lookup(int t, logic [63:0] addr);
      lookup_result_type r;
      int below, hit;
      r = '0;
      present[t] = 1'b1;
      below = 0;
      while (below < inst_cnt[t] && inst_off[t][below] < addr) below++;
      hit = -1;
      if (below < inst_cnt[t] && inst_off[t][below] == addr)
         hit = below;
      else if (below > 0 && (inst_off[t][below-1] + inst_len[t][below-1] > addr
                             || inst_len[t][below-1] == 0))
         hit = below - 1;
      if (hit >= 0) begin
         r.found  = 1'b1;
         r.symbol = inst_sym[t][hit];
         r.offset = inst_off[t][hit];
         r.size   = inst_len[t][hit];
      end
      r.present = 1'b1;
      return r;
   endfunction

   // send one item, predict on acceptance, then maybe idle
   task automatic send_item(logic cmd, logic [1:0] t, logic [63:0] addr, logic [63:0] len,
                            logic [15:0] sym, logic last);
      int gap;
      @(negedge clock);
      start          = 1'b1;
      req_command    = cmd;
      req_table_id   = t;
      req_address    = addr;
      req_entry_size = len;
      req_symbol_id  = sym;
      req_last_entry = last;
      do @(posedge clock); while (busy);
      if (cmd == srl_pkg::CMD_LOAD)
         expected_results.push_back(model_load(t, addr, len, sym, last));
      else
         expected_results.push_back(model_lookup(t, addr));
      // bursts with random gaps
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   task automatic load_entry(logic [1:0] t, logic [63:0] off, logic [63:0] len,
                             logic [15:0] sym, logic last);
      send_item(srl_pkg::CMD_LOAD, t, off, len, sym, last);
   endtask

   task automatic lookup(logic [1:0] t, logic [63:0] addr);
      send_item(srl_pkg::CMD_LOOKUP, t, addr, {$urandom, $urandom}, 16'($urandom),
                1'($urandom_range(0, 1)));
   endtask

   // hold off until every result is back
   task automatic drain;
      @(negedge clock);
      start = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // absent tables, open-ended, wrap, duplicates, extremes
   task automatic test_directed;
      lookup(2'd0, 64'd0);
      lookup(2'd0, '1);
      load_entry(2'd1, 64'd0, 64'd0, 16'h0000, 1'b0);
      load_entry(2'd1, 64'hFFFF_FFFF_FFFF_FFF0, 64'd32, 16'hFFFF, 1'b0);
      load_entry(2'd1, 64'h1000, 64'h10, 16'h1234, 1'b0);
      load_entry(2'd1, 64'h1000, 64'h10, 16'h5678, 1'b0);
      load_entry(2'd1, 64'h1000, 64'h20, 16'h9ABC, 1'b0);
      load_entry(2'd1, 64'h800, '1, 16'h00FF, 1'b1);
      lookup(2'd1, 64'h1000);
      lookup(2'd1, 64'h1018);
      lookup(2'd1, 64'h0);
      lookup(2'd1, 64'h5);
      lookup(2'd1, 64'h900);
      lookup(2'd1, 64'hFFFF_FFFF_FFFF_FFF8);
      lookup(2'd1, '1);
      lookup(2'd3, 64'h1000);
      load_entry(2'd3, 64'h40, 64'h8, 16'hA5A5, 1'b1);
      lookup(2'd3, 64'h3F);
      lookup(2'd3, 64'h47);
      lookup(2'd3, 64'h48);
      drain();
   endtask

   // overflow the pending buffer, last entry dropped yet installed
   task automatic test_full_table;
      for (int i = 0; i < TD + 3; i++)
         load_entry(2'd2, 64'h100 * i, 64'h80, i[15:0], i == TD + 2);
      for (int i = 0; i < 12; i++)
         lookup(2'd2, 64'h100 * $urandom_range(0, TD + 2) + $urandom_range(0, 255));
      lookup(2'd2, '1);
      // reinstall with fewer entries
      load_entry(2'd2, 64'h0, 64'h0, 16'h7777, 1'b1);
      lookup(2'd2, 64'h500);
      drain();
   endtask

   // random load sequences and lookups
   task automatic test_random(int items);
      int sent, n;
      logic [1:0]  t;
      logic [63:0] pool_base, off, len, prev_off, prev_len;
      sent = 0;
      while (sent < items) begin
         t = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 8);
            pool_base = ($urandom_range(0, 3) == 0) ? rand64() : {52'd0, 12'($urandom)};
            prev_off = pool_base;
            prev_len = 64'd16;
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(0, 3))
                  0: off = rand64();
                  1: off = prev_off;
                  default: off = pool_base + 64'h10 * $urandom_range(0, 7);
               endcase
               case ($urandom_range(0, 4))
                  0: len = 64'd0;
                  1: len = rand64();
                  2: len = prev_len;
                  default: len = 64'($urandom_range(1, 40));
               endcase
               if (off == prev_off && $urandom_range(0, 1)) len = prev_len;
               load_entry(t, off, len, 16'($urandom), i == n - 1);
               sent++;
               prev_off = off;
               prev_len = len;
               // broken sequence: lookup in the middle of a load
               if ($urandom_range(0, 9) == 0) begin
                  lookup(2'($urandom_range(0, 3)), rand64());
                  sent++;
               end
            end
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               if (inst_cnt[t] > 0 && $urandom_range(0, 4) != 0) begin
                  off = inst_off[t][$urandom_range(0, inst_cnt[t] - 1)];
                  off = off + 64'($signed($urandom_range(0, 48)) - 8);
               end else begin
                  off = rand64();
               end
               lookup(t, off);
               sent++;
            end
         end
         if ($urandom_range(0, 99) == 0) drain();
      end
      drain();
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_command    = srl_pkg::CMD_LOAD;
      req_table_id   = '0;
      req_address    = '0;
      req_entry_size = '0;
      req_symbol_id  = '0;
      req_last_entry = 1'b0;
      mismatches     = 0;
      cycles         = 0;
      burst_left     = 0;
      for (int t = 0; t < TC; t++) begin
         pend_cnt[t] = 0;
         inst_cnt[t] = 0;
         present[t]  = 1'b0;
      end
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_full_table();
      test_random(800);

      while (expected_results.size() != 0) @(posedge clock);
      repeat (1100) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
